/* hdl/sdbp_pkg.sv */
// Shared types and helpers for the sorted delta bit-pack encoder.
// Used by every module under hdl but sdbp_ram; depends on nothing.
package sdbp_pkg;

  localparam int unsigned MaxIdsDefault = 64;
  localparam int unsigned IdW    = 32;
  localparam int unsigned WordW  = 64;
  localparam int unsigned HdrW   = 5;
  localparam int unsigned BytesW = 9;
  localparam int unsigned KeptW  = 7;
  // stream length in bits, up to 32 + 5 + 64 * 32 with the default MAX_IDS
  localparam int unsigned PosW   = 12;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  typedef struct packed {
    logic            op;
    logic [IdW-1:0]  id_value;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]  packed_word;
    logic              last;
    logic [BytesW-1:0] total_bytes;
    logic [KeptW-1:0]  kept_count;
    logic              dup_seen;
    logic              overflow;
  } out_item_t;

  // command handed from the front queue to the back end
  typedef struct packed {
    logic           encode;
    logic [IdW-1:0] id;
  } cmd_t;

  // bits needed to hold v, at least one
  function automatic logic [5:0] width_for(logic [IdW-1:0] v);
    logic [5:0] n;
    n = 6'd1;
    for (int k = 0; k < IdW; k++) begin
      if (v[k]) n = 6'(k + 1);
    end
    return n;
  endfunction

endpackage

/* hdl/sorted_delta_bitpack_encoder_top.sv */
// Sorted delta bit-pack encoder: channel ports, APB register and the
// front queue / back end pair. Uses sdbp_pkg, sdbp_front, sdbp_back.
//
// Usage:
//   Input channel (item_valid/item_ready/item): op 0 loads one id, op 1
//   encodes all loaded ids and clears the store. Ids past MAX_IDS are dropped
//   and flagged as overflow on the last word of the next encode.
//   Output channel (res_valid/res_ready/res): 64-bit words of the packed
//   stream, LSB first; the last word carries size, kept count and flags.
//   APB register 0 (bit 0): unique_mode, to be written only while idle; the block does not enforce this.
// Operation:
//   A load keeps the store sorted by insertion: one read and one compare
//   step per shifted entry on the single store read port. An encode scans
//   the store for width and kept count, writes the header, then packs the
//   deltas and sends the output words. A two-entry queue in front lets new
//   transactions be taken while the back end works.
// Reset clears the queue, the id count, the overflow flag and unique_mode.
// A stalled receiver holds the current word and pauses the packer.
module sorted_delta_bitpack_encoder_top #(
  parameter int unsigned MAX_IDS = sdbp_pkg::MaxIdsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  sdbp_pkg::in_item_t  item,
  output logic                res_valid,
  input  logic                res_ready,
  output sdbp_pkg::out_item_t res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic           unique_mode;
  logic           cmd_valid;
  logic           cmd_ready;
  sdbp_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, unique_mode} : 32'd0;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      unique_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      unique_mode <= pwdata[0];
    end
  end

  sdbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  sdbp_back #(.MAX_IDS(MAX_IDS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .unique_mode(unique_mode),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

/* hdl/sdbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sdbp_front.sv */
// Front end: accepts input transactions, classifies them into commands
// and holds them in a two-entry queue for the back end. Uses sdbp_pkg.
module sdbp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sdbp_pkg::in_item_t item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output sdbp_pkg::cmd_t    cmd
);

  sdbp_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign item_ready = (fill != 2'd2);
  assign cmd_valid  = (fill != 2'd0);
  assign cmd        = slots[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = cmd_valid && cmd_ready;

  // store the classified command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].encode <= (item.op == sdbp_pkg::OP_ENCODE);
      slots[wr_ptr].id     <= item.id_value;
    end
  end

  // advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_full_no_push: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2 && !pop) |=> (fill == 2'd2))
    else $error("queue lost an entry while full");
  a_empty_no_pop: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 && !push) |=> (fill == 2'd0))
    else $error("queue gained an entry with no push");
`endif

endmodule

/* hdl/sdbp_back.sv */
// Back end: keeps the id store sorted by insertion on each load, then on
// encode scans for width and kept count and packs the stream. Uses sdbp_pkg, sdbp_ram.
module sdbp_back #(
  parameter int unsigned MAX_IDS = sdbp_pkg::MaxIdsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                unique_mode,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  sdbp_pkg::cmd_t      cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output sdbp_pkg::out_item_t res
);

  localparam int unsigned CW = $clog2(MAX_IDS + 1);
  localparam int unsigned AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_INS_RD   = 10'b0000000010,
    S_INS_CMP  = 10'b0000000100,
    S_INS_PUT  = 10'b0000001000,
    S_SCAN_RD  = 10'b0000010000,
    S_SCAN_USE = 10'b0000100000,
    S_HDR      = 10'b0001000000,
    S_EMIT_RD  = 10'b0010000000,
    S_EMIT_USE = 10'b0100000000,
    S_FLUSH    = 10'b1000000000
  } state_t;

  state_t                      state;
  logic [CW-1:0]               load_count;
  logic                        overflow_flag;
  logic [31:0]                 key;
  logic [CW-1:0]               idx;
  logic [31:0]                 prev;
  logic [31:0]                 max_gap;
  logic [sdbp_pkg::KeptW-1:0]  kept;
  logic                        dup;
  logic [5:0]                  wid;
  logic [127:0]                acc;
  logic [6:0]                  acc_bits;
  logic [sdbp_pkg::PosW-1:0]   tot;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [31:0]   delta;
  logic          skip;
  logic          slot_free;
  logic          emit;
  logic [sdbp_pkg::PosW-1:0] tot_round;

  sdbp_ram #(.WIDTH(32), .DEPTH(MAX_IDS)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cmd_ready = (state == S_IDLE);
  assign slot_free = !res_valid || res_ready;
  assign emit      = slot_free &&
                     (((state == S_EMIT_RD) && (acc_bits > 7'd64)) || (state == S_FLUSH));
  assign delta     = rdata - prev;
  assign skip      = (idx != '0) && (delta == 32'd0) && unique_mode;
  assign tot_round = tot + sdbp_pkg::PosW'(7);

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = key;
    raddr = idx[AW-1:0];
    unique case (state)
      S_INS_RD: raddr = AW'(idx - CW'(1));
      S_INS_CMP: begin
        if (rdata > key) begin
          we    = 1'b1;
          wdata = rdata;
        end
      end
      S_INS_PUT: we = 1'b1;
      default: ;
    endcase
  end

  // hold the output word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_count    <= '0;
      overflow_flag <= 1'b0;
      acc_bits      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            key <= cmd.id;
            if (!cmd.encode) begin
              idx <= load_count;
              if (load_count == CW'(MAX_IDS)) overflow_flag <= 1'b1;
              else if (load_count == '0) state <= S_INS_PUT;
              else state <= S_INS_RD;
            end else if (load_count == '0) begin
              kept     <= '0;
              dup      <= 1'b0;
              acc      <= '0;
              acc_bits <= 7'd32;
              tot      <= sdbp_pkg::PosW'(32);
              state    <= S_FLUSH;
            end else begin
              idx     <= '0;
              prev    <= '0;
              max_gap <= '0;
              kept    <= '0;
              dup     <= 1'b0;
              state   <= S_SCAN_RD;
            end
          end
        end
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          // shift the larger entry up, or drop the key in place
          if (rdata > key) begin
            idx   <= idx - CW'(1);
            state <= (idx == CW'(1)) ? S_INS_PUT : S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          load_count <= load_count + CW'(1);
          state      <= S_IDLE;
        end
        S_SCAN_RD: state <= S_SCAN_USE;
        S_SCAN_USE: begin
          if (delta > max_gap) max_gap <= delta;
          if (!skip) kept <= kept + sdbp_pkg::KeptW'(1);
          if ((idx != '0) && (delta == 32'd0) && !unique_mode) dup <= 1'b1;
          prev <= rdata;
          idx  <= idx + CW'(1);
          state <= (idx + CW'(1) == load_count) ? S_HDR : S_SCAN_RD;
        end
        S_HDR: begin
          wid      <= sdbp_pkg::width_for(max_gap);
          acc      <= {91'd0, 5'(sdbp_pkg::width_for(max_gap) - 6'd1),
                       25'd0, kept};
          acc_bits <= 7'd37;
          tot      <= sdbp_pkg::PosW'(37);
          idx      <= '0;
          prev     <= '0;
          state    <= S_EMIT_RD;
        end
        S_EMIT_RD: begin
          // drain a full word before the next delta goes in
          if (acc_bits > 7'd64) begin
            if (slot_free) begin
              res.packed_word <= acc[63:0];
              res.last        <= 1'b0;
              res.total_bytes <= '0;
              res.kept_count  <= '0;
              res.dup_seen    <= 1'b0;
              res.overflow    <= 1'b0;
              acc      <= acc >> 64;
              acc_bits <= acc_bits - 7'd64;
            end
          end else begin
            state <= S_EMIT_USE;
          end
        end
        S_EMIT_USE: begin
          if (!skip) begin
            acc      <= acc | ({96'd0, delta} << acc_bits);
            acc_bits <= acc_bits + 7'(wid);
            tot      <= tot + sdbp_pkg::PosW'(wid);
            prev     <= rdata;
          end
          idx   <= idx + CW'(1);
          state <= (idx + CW'(1) == load_count) ? S_FLUSH : S_EMIT_RD;
        end
        S_FLUSH: begin
          if (slot_free) begin
            res.packed_word <= acc[63:0];
            acc             <= acc >> 64;
            if (acc_bits <= 7'd64) begin
              res.last        <= 1'b1;
              res.total_bytes <= tot_round[sdbp_pkg::BytesW+2:3];
              res.kept_count  <= kept;
              res.dup_seen    <= dup;
              res.overflow    <= overflow_flag;
              acc_bits        <= '0;
              load_count      <= '0;
              overflow_flag   <= 1'b0;
              state           <= S_IDLE;
            end else begin
              res.last        <= 1'b0;
              res.total_bytes <= '0;
              res.kept_count  <= '0;
              res.dup_seen    <= 1'b0;
              res.overflow    <= 1'b0;
              acc_bits        <= acc_bits - 7'd64;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    load_count <= CW'(MAX_IDS))
    else $error("load count past capacity");
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc_bits <= 7'd96)
    else $error("bit buffer overrun");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (acc_bits == 7'd0))
    else $error("bits left in buffer after encode");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for sorted_delta_bitpack_encoder_top: loads ids,
// encodes, and compares each packed word against an in-bench encoder model.
// Depends on sdbp_pkg and the RTL under hdl.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 64;
  localparam int unsigned REG_UNIQUE = 0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  sdbp_pkg::in_item_t item = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  sdbp_pkg::out_item_t res;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sorted_delta_bitpack_encoder_top u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // encoder model state
  logic [31:0] model_ids[CAP];
  int unsigned model_count;
  logic model_ovf;
  logic model_unique;
  sdbp_pkg::out_item_t word_queue[$];

  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_cycles = 0;

  // predict the words of one encode and queue them
  task automatic predict_encode();
    logic [31:0] s[$];
    logic [31:0] key, gap, d, prev;
    logic [63:0] words[34];
    int unsigned n, w, pos, kept, nw, bytes;
    logic dup;
    n = model_count;
    s = {};
    for (int i = 0; i < n; i++) s.push_back(model_ids[i]);
    s.sort();
    for (int i = 0; i < 34; i++) words[i] = '0;
    pos = 32; kept = 0; dup = 1'b0; prev = '0;
    if (n > 0) begin
      gap = s[0];
      for (int i = 1; i < n; i++) begin
        d = s[i] - s[i-1];
        if (d > gap) gap = d;
      end
      w = 1;
      for (int k = 0; k < 32; k++) if (gap[k]) w = k + 1;
      for (int b = 0; b < 5; b++) words[(pos+b)/64][(pos+b)%64] = 1'((w - 1) >> b);
      pos += 5;
      for (int i = 0; i < n; i++) begin
        d = s[i] - prev;
        if (d == 0 && i != 0) begin
          if (model_unique) continue;
          dup = 1'b1;
        end
        for (int b = 0; b < w; b++) words[(pos+b)/64][(pos+b)%64] = d[b];
        prev = s[i];
        pos += w;
        kept++;
      end
    end
    for (int b = 0; b < 32; b++) words[0][b] = 1'(kept >> b);
    bytes = (pos + 7) / 8;
    nw = (pos + 63) / 64;
    for (int i = 0; i < nw; i++) begin
      sdbp_pkg::out_item_t o;
      o = '0;
      o.packed_word = words[i];
      if (i + 1 == nw) begin
        o.last = 1'b1;
        o.total_bytes = bytes[8:0];
        o.kept_count = kept[6:0];
        o.dup_seen = dup;
        o.overflow = model_ovf;
      end
      word_queue.push_back(o);
    end
    model_count = 0;
    model_ovf = 1'b0;
  endtask

  // send one transaction, update the model on acceptance
  task automatic send_item(input logic op, input logic [31:0] id);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{op: op, id_value: id};
    do @(posedge clk); while (!item_ready);
    if (op == sdbp_pkg::OP_ENCODE) predict_encode();
    else if (model_count < CAP) model_ids[model_count++] = id;
    else model_ovf = 1'b1;
  endtask

  // receiver ready, with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (rst) res_ready <= 1'b0;
    else if (hold_off_cycles != 0) begin
      res_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else res_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (word_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", res);
      end else begin
        sdbp_pkg::out_item_t e;
        e = word_queue.pop_front();
        if (res.packed_word !== e.packed_word || res.last !== e.last ||
            res.total_bytes !== e.total_bytes || res.kept_count !== e.kept_count ||
            res.dup_seen !== e.dup_seen || res.overflow !== e.overflow) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp word=%h last=%0d bytes=%0d kept=%0d dup=%0d ovf=%0d",
                     e.packed_word, e.last, e.total_bytes, e.kept_count, e.dup_seen,
                     e.overflow, "\n          got word=%h last=%0d bytes=%0d kept=%0d dup=%0d ovf=%0d",
                     res.packed_word, res.last, res.total_bytes, res.kept_count,
                     res.dup_seen, res.overflow);
        end
      end
    end
  end

  // drop valid, wait for all words, then let the block settle
  task automatic drain();
    item_valid <= 1'b0;
    while (word_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned index, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * index); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (index == REG_UNIQUE) model_unique = value[0];
  endtask

  task automatic test_directed();
    write_reg(REG_UNIQUE, 32'd0);
    send_item(sdbp_pkg::OP_ENCODE, 0);             // empty encode
    send_item(sdbp_pkg::OP_LOAD, 0);               // first id zero
    send_item(sdbp_pkg::OP_ENCODE, 0);
    send_item(sdbp_pkg::OP_LOAD, 32'hFFFF_FFFF);
    send_item(sdbp_pkg::OP_LOAD, 0);
    send_item(sdbp_pkg::OP_LOAD, 32'hFFFF_FFFF);   // duplicate kept
    send_item(sdbp_pkg::OP_ENCODE, 32'h1234_5678);
    drain();
    write_reg(REG_UNIQUE, 32'd1);
    send_item(sdbp_pkg::OP_LOAD, 7); send_item(sdbp_pkg::OP_LOAD, 7);
    send_item(sdbp_pkg::OP_LOAD, 3);
    send_item(sdbp_pkg::OP_LOAD, 0); send_item(sdbp_pkg::OP_LOAD, 0);
    send_item(sdbp_pkg::OP_ENCODE, 0);
    send_item(sdbp_pkg::OP_LOAD, 32'hAAAA_5555);
    send_item(sdbp_pkg::OP_LOAD, 32'h5555_AAAA);
    send_item(sdbp_pkg::OP_ENCODE, 0);
    drain();
  endtask

  // fill past capacity to hit overflow and the longest streams
  task automatic test_overflow(input logic uniq);
    write_reg(REG_UNIQUE, 32'(uniq));
    for (int i = 0; i < CAP + 1; i++) send_item(sdbp_pkg::OP_LOAD, $urandom());
    send_item(sdbp_pkg::OP_ENCODE, 0);
    drain();
  endtask

  task automatic test_random(input int unsigned idle, input int unsigned stall,
                             input int unsigned items);
    int unsigned sent, n;
    logic [31:0] base;
    send_idle_pct = idle; recv_stall_pct = stall;
    write_reg(REG_UNIQUE, 32'($urandom_range(1, 0)));
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(4, 0);
      base = $urandom();
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(3, 0))
          0: send_item(sdbp_pkg::OP_LOAD, $urandom());
          1: send_item(sdbp_pkg::OP_LOAD, base);
          default: send_item(sdbp_pkg::OP_LOAD, base + $urandom_range(300, 0));
        endcase
      end
      send_item(sdbp_pkg::OP_ENCODE, $urandom());
      sent += n + 1;
    end
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  // receiver holds off while the sender keeps going
  task automatic test_backpressure();
    hold_off_cycles = 200;
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < 3; i++) send_item(sdbp_pkg::OP_LOAD, $urandom_range(1000, 0));
      send_item(sdbp_pkg::OP_ENCODE, 0);
    end
    drain();
  endtask

  initial begin
    model_count = 0; model_ovf = 1'b0; model_unique = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow(1'b0);
    test_random(0, 0, 6);
    test_random(75, 0, 6);
    test_random(0, 75, 6);
    test_random(19, 19, 6);
    test_backpressure();
    if (errors == 0 && word_queue.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

/* filelist.f */
hdl/sdbp_pkg.sv
hdl/sdbp_ram.sv
hdl/sdbp_front.sv
hdl/sdbp_back.sv
hdl/sorted_delta_bitpack_encoder_top.sv
tb/testbench.sv
